[rtl/core/spta_pkg.sv]
// Shared types, constants and codes for the sorted polynomial term accumulator.
`timescale 1ns / 1ps
package spta_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Result status codes.
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_MERGED   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_TERM     = 2'd3;

  // Operation codes.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Input beat.
  typedef struct packed {
    logic              opcode;
    logic signed [15:0] coefficient;
    logic signed [15:0] exponent;
  } in_t;

  // Output beat.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] term_coefficient;
    logic signed [15:0] term_exponent;
    logic               empty_res;
    logic               last;
  } out_t;

  // One table entry as held by a cell.
  typedef struct packed {
    logic signed [15:0] exponent;
    logic signed [31:0] coefficient;
  } entry_t;

  // Commands broadcast along the cell row.
  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_COMPARE,
    CMD_MERGE,
    CMD_INSERT,
    CMD_ROTATE
  } cell_cmd_t;

  // Broadcast control: the command and the term being added.
  typedef struct packed {
    cell_cmd_t          cmd;
    logic signed [15:0] exponent;
    logic signed [15:0] coefficient;
  } cell_ctl_t;

endpackage

[rtl/core/spta_cell.sv]
// One table cell: holds an entry, compares it, merges, shifts in or rotates.
`timescale 1ns / 1ps
module spta_cell (
  input  logic               clk,
  input  logic               rst,
  input  spta_pkg::cell_ctl_t ctl,
  input  logic               valid,
  input  spta_pkg::entry_t   left,
  input  spta_pkg::entry_t   right,
  input  logic               gt_left,
  output spta_pkg::entry_t   entry,
  output logic               gt,
  output logic               eq
);
  import spta_pkg::*;

  logic signed [32:0] sum;
  logic signed [31:0] sum_sat;

  // Saturating sum of the stored coefficient and the incoming one.
  assign sum = {entry.coefficient[31], entry.coefficient}
             + {{17{ctl.coefficient[15]}}, ctl.coefficient};
  always_comb begin
    if (sum[32] != sum[31]) begin
      sum_sat = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  // Compare flags are taken once per add and held for the update state.
  always_ff @(posedge clk) begin
    if (rst) begin
      gt <= 1'b0;
      eq <= 1'b0;
    end else if (ctl.cmd == CMD_COMPARE) begin
      gt <= valid && (entry.exponent > ctl.exponent);
      eq <= valid && (entry.exponent == ctl.exponent);
    end
  end

  // Entry update.
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_MERGE: begin
        if (eq) begin
          entry.coefficient <= sum_sat;
        end
      end
      CMD_INSERT: begin
        if (!gt) begin
          if (gt_left) begin
            entry.exponent    <= ctl.exponent;
            entry.coefficient <= {{16{ctl.coefficient[15]}}, ctl.coefficient};
          end else begin
            entry <= left;
          end
        end
      end
      CMD_ROTATE: begin
        entry <= right;
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/core/sorted_polynomial_term_accumulator_core.sv]
// Top level: cell row, control sequencer and output register of the accumulator.
`timescale 1ns / 1ps
// Add: accepted, then a compare state and an update state; the update state
// waits while the result side stalls, then loads the status beat and goes idle.
// Readout: the row rotates once per cycle through all TABLE_DEPTH cells, waiting
// while the result side stalls, then a flush state loads the last beat.
// Reset clears the entry count and the handshake state; entry contents stay unset.
module sorted_polynomial_term_accumulator_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  spta_pkg::in_t  cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spta_pkg::out_t rsp
);
  import spta_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMPARE,
    S_UPDATE,
    S_READ,
    S_FLUSH
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   step;
  logic signed [15:0] op_exponent;
  logic signed [15:0] op_coefficient;
  entry_t             pend;
  logic               pend_valid;

  cell_ctl_t          ctl;
  entry_t             cells [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] gt_v;
  logic [TABLE_DEPTH-1:0] eq_v;
  logic [TABLE_DEPTH-1:0] valid_v;

  logic   can_push;
  logic   head_live;
  logic   read_go;
  logic   full;
  logic   any_eq;
  logic   rsp_load;

  assign can_push  = !rsp_valid || rsp_ready;
  assign full      = (count == CNT_W'(TABLE_DEPTH));
  assign any_eq    = |eq_v;
  assign head_live = (CNT_W'(step) < count) && (cells[0].coefficient != 32'sd0);
  assign read_go   = !(head_live && pend_valid) || can_push;
  assign cmd_ready = (state == S_IDLE);

  // A result beat is loaded into the output register in this cycle.
  assign rsp_load = ((state == S_UPDATE) && can_push)
                 || ((state == S_READ) && read_go && head_live && pend_valid)
                 || ((state == S_FLUSH) && can_push);

  // Command broadcast to the cell row.
  always_comb begin
    ctl.exponent    = op_exponent;
    ctl.coefficient = op_coefficient;
    ctl.cmd         = CMD_HOLD;
    case (state)
      S_COMPARE: ctl.cmd = CMD_COMPARE;
      S_UPDATE: begin
        if (can_push) begin
          if (any_eq) begin
            ctl.cmd = CMD_MERGE;
          end else if (!full) begin
            ctl.cmd = CMD_INSERT;
          end
        end
      end
      S_READ: begin
        if (read_go) begin
          ctl.cmd = CMD_ROTATE;
        end
      end
      default: ctl.cmd = CMD_HOLD;
    endcase
  end

  // Row of cells; inserts shift toward the tail, readout rotates toward the head.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign valid_v[i] = (CNT_W'(i) < count);
    spta_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .valid   (valid_v[i]),
      .left    (cells[(i == 0) ? 0 : i - 1]),
      .right   (cells[(i == TABLE_DEPTH - 1) ? 0 : i + 1]),
      .gt_left ((i == 0) ? 1'b1 : gt_v[(i == 0) ? 0 : i - 1]),
      .entry   (cells[i]),
      .gt      (gt_v[i]),
      .eq      (eq_v[i])
    );
  end

  // Sequencer with the entry count and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      step       <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op_exponent    <= cmd.exponent;
            op_coefficient <= cmd.coefficient;
            step           <= '0;
            pend_valid     <= 1'b0;
            state          <= (cmd.opcode == OP_READ) ? S_READ : S_COMPARE;
          end
        end
        S_COMPARE: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (can_push) begin
            rsp.term_coefficient  <= '0;
            rsp.term_exponent     <= '0;
            rsp.empty_res         <= 1'b0;
            rsp.last              <= 1'b1;
            if (any_eq) begin
              rsp.status <= ST_MERGED;
            end else if (full) begin
              rsp.status <= ST_FULL;
            end else begin
              rsp.status <= ST_INSERTED;
              count      <= count + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        S_READ: begin
          if (read_go) begin
            // A new live term releases the one held back before it.
            if (head_live && pend_valid) begin
              rsp.status           <= ST_TERM;
              rsp.term_coefficient <= pend.coefficient;
              rsp.term_exponent    <= pend.exponent;
              rsp.empty_res        <= 1'b0;
              rsp.last             <= 1'b0;
            end
            if (head_live) begin
              pend       <= cells[0];
              pend_valid <= 1'b1;
            end
            step <= step + IDX_W'(1);
            if (step == IDX_W'(TABLE_DEPTH - 1)) begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (can_push) begin
            rsp.status    <= ST_TERM;
            rsp.last      <= 1'b1;
            rsp.empty_res <= !pend_valid;
            if (pend_valid) begin
              rsp.term_coefficient <= pend.coefficient;
              rsp.term_exponent    <= pend.exponent;
            end else begin
              rsp.term_coefficient <= '0;
              rsp.term_exponent    <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/spta_checker.sv]
// Port-level checks for the accumulator and their binding to the top level.
`timescale 1ns / 1ps
module spta_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input spta_pkg::out_t rsp
);
  import spta_pkg::*;

  // A pending result beat stays up until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result beat dropped or changed while stalled");

  // After a command beat the block is not ready in the cycle after it.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted on consecutive cycles");

  // An add answers with exactly one beat, flagged last and never empty.
  a_add_beat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_TERM) |-> rsp.last && !rsp.empty_res)
    else $error("add status beat not last or flagged empty");

  // The empty marker is a lone zero term.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.empty_res |->
      rsp.last && (rsp.status == ST_TERM) && (rsp.term_coefficient == 32'sd0))
    else $error("malformed empty readout beat");

  // A listed term always carries a nonzero coefficient.
  a_term_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_TERM) && !rsp.empty_res |->
      rsp.term_coefficient != 32'sd0)
    else $error("readout listed a zero coefficient");

endmodule

bind sorted_polynomial_term_accumulator_core spta_checker u_spta_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_ready (cmd_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

[test/sorted_polynomial_term_accumulator_core_test.sv]
// Self-checking testbench for the sorted polynomial term accumulator core.
`timescale 1ns / 1ps
module sorted_polynomial_term_accumulator_core_test;
  import spta_pkg::*;

  localparam int     RANDOM_ITEMS     = 140;
  localparam int     LONG_HOLD_CYCLES = 400;
  localparam longint COEF_MAX         = 64'sd2147483647;
  localparam longint COEF_MIN         = -64'sd2147483648;

  // One row of the directed table; a typed row carries its own status and empty flag.
  typedef struct {
    in_t        beat;
    bit         typed;
    logic [1:0] status;
    bit         empty_flag;
  } stim_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic rsp_ready = 1'b0;
  in_t  cmd       = '0;
  logic cmd_ready;
  logic rsp_valid;
  out_t rsp;

  // Shadow copy of the term table, kept in descending exponent order.
  logic signed [15:0] term_exponents    [TABLE_DEPTH];
  logic signed [31:0] term_coefficients [TABLE_DEPTH];
  int                 term_count = 0;

  out_t      beat_results    [$];
  out_t      pending_results [$];
  stim_row_t directed_rows   [$];
  int        error_count       = 0;
  bit        no_idle           = 1'b0;
  bit        long_hold_request = 1'b0;

  sorted_polynomial_term_accumulator_core uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one accepted beat to the shadow table and lists the beats it must produce.
  function automatic void accumulate_beat(input in_t beat);
    int     pos;
    int     i;
    longint total;
    out_t   res;
    beat_results = {};
    res = '0;
    res.last = 1'b1;
    if (beat.opcode == OP_ADD) begin
      pos = 0;
      while (pos < term_count && term_exponents[pos] > $signed(beat.exponent)) pos++;
      if (pos < term_count && term_exponents[pos] == $signed(beat.exponent)) begin
        total = longint'(term_coefficients[pos]) + longint'($signed(beat.coefficient));
        if (total > COEF_MAX) total = COEF_MAX;
        if (total < COEF_MIN) total = COEF_MIN;
        term_coefficients[pos] = total[31:0];
        res.status = ST_MERGED;
      end else if (term_count >= TABLE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        for (i = term_count; i > pos; i--) begin
          term_exponents[i]    = term_exponents[i - 1];
          term_coefficients[i] = term_coefficients[i - 1];
        end
        term_exponents[pos]    = beat.exponent;
        term_coefficients[pos] = 32'($signed(beat.coefficient));
        term_count++;
        res.status = ST_INSERTED;
      end
      beat_results.push_back(res);
    end else begin
      // Readout lists nonzero entries only; zero-sum entries stay but are skipped.
      for (i = 0; i < term_count; i++) begin
        if (term_coefficients[i] != 0) begin
          res.status           = ST_TERM;
          res.term_coefficient = term_coefficients[i];
          res.term_exponent    = term_exponents[i];
          res.empty_res        = 1'b0;
          res.last             = 1'b0;
          beat_results.push_back(res);
        end
      end
      if (beat_results.size() == 0) begin
        res.status    = ST_TERM;
        res.empty_res = 1'b1;
        res.last      = 1'b1;
        beat_results.push_back(res);
      end else begin
        beat_results[beat_results.size() - 1].last = 1'b1;
      end
    end
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  // Compares one received beat with the oldest outstanding expectation.
  task automatic check_result(input out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result beat: status %0d coefficient %0d exponent %0d",
             got.status, got.term_coefficient, got.term_exponent);
      error_count++;
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        error_count++;
      end
      if (got.term_coefficient !== want.term_coefficient) begin
        $error("term_coefficient: expected %0d, got %0d",
               want.term_coefficient, got.term_coefficient);
        error_count++;
      end
      if (got.term_exponent !== want.term_exponent) begin
        $error("term_exponent: expected %0d, got %0d", want.term_exponent, got.term_exponent);
        error_count++;
      end
      if (got.empty_res !== want.empty_res) begin
        $error("empty_res: expected %0d, got %0d", want.empty_res, got.empty_res);
        error_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        error_count++;
      end
    end
  endtask

  // Holds the beat on the command side until the core takes it.
  task automatic offer_beat(input in_t beat, input int gap);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd       <= beat;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
  endtask

  // Sends a beat, then queues what the shadow table says it produces.
  task automatic send_checked(input in_t beat, input int gap);
    offer_beat(beat, gap);
    accumulate_beat(beat);
    foreach (beat_results[k]) pending_results.push_back(beat_results[k]);
  endtask

  task automatic wait_for_drain();
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic op, input int coef, input int expo, input bit typed,
                         input logic [1:0] status, input bit empty_flag);
    stim_row_t row;
    row.beat.opcode      = op;
    row.beat.coefficient = coef[15:0];
    row.beat.exponent    = expo[15:0];
    row.typed            = typed;
    row.status           = status;
    row.empty_flag       = empty_flag;
    directed_rows.push_back(row);
  endtask

  // Result side: random stalls per beat, plus one long hold-off on request.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      int stall;
      if (long_hold_request) begin
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_request = 1'b0;
      end
      stall = draw_gap();
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      check_result(rsp);
    end
  end

  // Command side: directed table, then random traffic.
  initial begin
    in_t  beat;
    out_t typed_res;
    int   pick;
    int   roll;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table, zero-sum entries, field extremes, ordering and ignored readout fields.
    add_row(OP_READ,     -1,     -1, 1'b1, ST_TERM,     1'b1);
    add_row(OP_ADD,       5,      0, 1'b1, ST_INSERTED, 1'b0);
    add_row(OP_ADD,      -5,      0, 1'b1, ST_MERGED,   1'b0);
    add_row(OP_READ,      0,      0, 1'b1, ST_TERM,     1'b1);
    add_row(OP_ADD,   32767,  32767, 1'b1, ST_INSERTED, 1'b0);
    add_row(OP_ADD,  -32768, -32768, 1'b1, ST_INSERTED, 1'b0);
    add_row(OP_ADD,      -1,     -1, 1'b1, ST_INSERTED, 1'b0);
    add_row(OP_ADD,       7,      0, 1'b1, ST_MERGED,   1'b0);
    add_row(OP_ADD,   32767,  32767, 1'b1, ST_MERGED,   1'b0);
    add_row(OP_ADD,  -32768, -32768, 1'b1, ST_MERGED,   1'b0);
    add_row(OP_ADD,       0,    100, 1'b1, ST_INSERTED, 1'b0);
    add_row(OP_ADD,       1,     50, 1'b1, ST_INSERTED, 1'b0);
    add_row(OP_ADD,       3,   -100, 1'b1, ST_INSERTED, 1'b0);
    add_row(OP_READ,  12345,   -777, 1'b0, ST_TERM,     1'b0);
    add_row(OP_ADD,      -7,      0, 1'b1, ST_MERGED,   1'b0);
    add_row(OP_ADD,   21845,  10922, 1'b1, ST_INSERTED, 1'b0);
    add_row(OP_ADD,  -21846, -10923, 1'b1, ST_INSERTED, 1'b0);
    add_row(OP_ADD,  -32768,     -1, 1'b1, ST_MERGED,   1'b0);
    add_row(OP_READ,      0,      0, 1'b0, ST_TERM,     1'b0);

    foreach (directed_rows[r]) begin
      offer_beat(directed_rows[r].beat, draw_gap());
      accumulate_beat(directed_rows[r].beat);
      if (directed_rows[r].typed) begin
        typed_res           = '0;
        typed_res.status    = directed_rows[r].status;
        typed_res.empty_res = directed_rows[r].empty_flag;
        typed_res.last      = 1'b1;
        pending_results.push_back(typed_res);
      end else begin
        foreach (beat_results[k]) pending_results.push_back(beat_results[k]);
      end
    end

    // Sender pause: let every outstanding beat come back before the random run.
    wait_for_drain();

    // Random traffic: merges into live entries, new exponents until the table is full,
    // zero-sum merges and readouts, with idle-free stretches.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n % 40) >= 30;
      if (n == 20) long_hold_request = 1'b1;
      if (n == 80) wait_for_drain();
      beat.coefficient = 16'($urandom);
      beat.exponent    = 16'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        beat.opcode = OP_READ;
      end else begin
        beat.opcode = OP_ADD;
        if (roll < 25) beat.coefficient = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        if (term_count > 0 && $urandom_range(0, 1) != 0) begin
          pick = $urandom_range(0, term_count - 1);
          beat.exponent = term_exponents[pick];
          if ($urandom_range(0, 3) == 0 && term_coefficients[pick] > -32768 &&
              term_coefficients[pick] <= 32767) begin
            beat.coefficient = 16'(-term_coefficients[pick]);
          end
        end
      end
      send_checked(beat, draw_gap());
    end

    wait_for_drain();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("sorted_polynomial_term_accumulator_core_test: clean");
    end else begin
      $display("sorted_polynomial_term_accumulator_core_test: errors");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #60000000;
    $display("sorted_polynomial_term_accumulator_core_test: errors");
    $finish;
  end

endmodule

[sorted_polynomial_term_accumulator_core.f]
rtl/core/spta_pkg.sv
rtl/core/spta_cell.sv
rtl/core/sorted_polynomial_term_accumulator_core.sv
rtl/core/spta_checker.sv
test/sorted_polynomial_term_accumulator_core_test.sv
